### src/trm_pkg.sv
// ----------------------------------------------------------------------------
// Throughput rate monitor package
// Shared widths, request and result codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int unsigned DVD_W = 64;  // divider dividend and quotient width
  localparam int unsigned DVS_W = 48;  // divider divisor width
  localparam int unsigned DCNT_W = 6;  // divider step counter width

  localparam logic [31:0] CNT32_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0] PERMILLE = 10'd1000;
  localparam logic [10:0] ROUND_HALF = 11'd5;
  localparam logic [7:0] DIV10_RECIP = 8'd205;  // 205 / 2048 for division by ten

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_BITRATE = 2'd1,
    REQ_REPORT  = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  typedef enum logic {
    KIND_BITRATE = 1'b0,
    KIND_REPORT  = 1'b1
  } report_kind_e;

  typedef enum logic {
    CFG_WINDOW   = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BR_BPS,
    ST_BR_MEAN_GO,
    ST_BR_WIN_GO,
    ST_BR_CUM,
    ST_BR_WIN,
    ST_RP_FR_GO,
    ST_RP_FR,
    ST_RP_CUM_GO,
    ST_RP_CUM,
    ST_RP_PCT_GO,
    ST_RP_PCT,
    ST_DONE
  } state_e;

endpackage

### src/trm_req_if.sv
// ----------------------------------------------------------------------------
// Throughput rate monitor request channel
// Valid/ready channel carrying one request.
// ----------------------------------------------------------------------------
interface trm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [23:0] frame_bytes;
  logic [31:0] elapsed_us;
  logic [31:0] cpu_idle_ticks;
  logic [31:0] cpu_total_ticks;

  modport source (output valid, req_type, frame_bytes, elapsed_us, cpu_idle_ticks,
                  cpu_total_ticks, input ready);
  modport sink (input valid, req_type, frame_bytes, elapsed_us, cpu_idle_ticks,
                cpu_total_ticks, output ready);
endinterface

### src/trm_res_if.sv
// ----------------------------------------------------------------------------
// Throughput rate monitor result channel
// Valid/ready channel carrying one result.
// ----------------------------------------------------------------------------
interface trm_res_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [39:0] bits_per_second;
  logic [47:0] mean_bits_q8;
  logic [23:0] frames_rate_q8;
  logic [23:0] mean_frames_rate_q8;
  logic [6:0]  cpu_busy_percent;

  modport source (output valid, report_kind, bits_per_second, mean_bits_q8, frames_rate_q8,
                  mean_frames_rate_q8, cpu_busy_percent, input ready);
  modport sink (input valid, report_kind, bits_per_second, mean_bits_q8, frames_rate_q8,
                mean_frames_rate_q8, cpu_busy_percent, output ready);
endinterface

### src/trm_div.sv
// ----------------------------------------------------------------------------
// Throughput rate monitor divider
// Restoring divider, one quotient bit per cycle, shared by every quotient.
// ----------------------------------------------------------------------------
module trm_div
  import trm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]  acc_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, acc_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // The dividend shifts out at the top while quotient bits enter below.
      acc_q <= {acc_q[DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

### src/trm_win_mem.sv
// ----------------------------------------------------------------------------
// Throughput rate monitor window store
// Bitrate sample memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module trm_win_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [39:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [39:0]   rdata_o
);

  logic [39:0] mem [DEPTH];
  logic [39:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/throughput_rate_monitor.sv
// ----------------------------------------------------------------------------
// Throughput rate monitor
// Byte and frame counters, bitrate mean over a window, frame rate and CPU load.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req_i   | in  | req_type, frame_bytes, elapsed_us, cpu_idle_ticks, cpu_total_ticks
//  res_o   | out | report_kind, bits_per_second, mean_bits_q8, frames_rate_q8,
//          |     | mean_frames_rate_q8, cpu_busy_percent
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (window_length, interval_ms)
//
// A frame request is handled in the cycle it is accepted. A bitrate tick divides
// for the bitrate and then the mean (over the window when one is set) or, with a
// zero interval, not at all; a report tick divides for the frame rate, the mean and,
// with a nonzero tick delta, the busy percentage; each a 64-step shared-divider pass.
// No clearing pass follows reset; unwritten window entries read as zero.
// The request side is not ready until a tick's result sits in the output register.
// ----------------------------------------------------------------------------
module throughput_rate_monitor
  import trm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  trm_req_if.sink     req_i,
  trm_res_if.source   res_o
);

  localparam int unsigned SW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CW    = (WW > 7) ? WW : 7;
  localparam int unsigned SUM_W = 41 + $clog2(WINDOW_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

  state_e state_q, state_d;

  logic [6:0]       win_len_q;
  logic [15:0]      interval_q;
  logic [47:0]      bytes_q;
  logic [31:0]      frames_q;
  logic [31:0]      br_samples_q;
  logic [31:0]      rp_samples_q;
  logic [39:0]      latest_q;
  logic [47:0]      mean_br_q;
  logic [SUM_W-1:0] sum_q;
  logic [SW-1:0]    slot_q;
  logic [23:0]      mean_fr_q;
  logic [31:0]      last_idle_q;
  logic [31:0]      last_total_q;

  logic             kind_q;
  logic             neg_q;
  logic [63:0]      prod_q;
  logic [31:0]      us_q;
  logic [31:0]      di_q;
  logic [31:0]      dt_q;
  logic [23:0]      fr_q;
  logic [6:0]       pct_q;

  logic             out_valid_q;
  logic             out_kind_q;
  logic [39:0]      out_bps_q;
  logic [47:0]      out_mean_q;
  logic [23:0]      out_fr_q;
  logic [23:0]      out_mfr_q;
  logic [6:0]       out_pct_q;

  logic             in_ready;
  logic             in_acc;
  logic             out_free;
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic             mem_we;
  logic [39:0]      mem_rdata;

  logic [CW-1:0]    w_eff;
  logic [48:0]      bytes_sum;
  logic [63:0]      bytes_x8000;
  logic [51:0]      frame_prod;
  logic [31:0]      di_now;
  logic [31:0]      dt_now;
  logic [31:0]      br_n;
  logic [31:0]      rp_n;
  logic [47:0]      br_x;
  logic [39:0]      old_val;
  logic [SUM_W-1:0] sum_new;
  logic [31:0]      busy_ticks;
  logic [41:0]      pct_prod;
  logic [18:0]      pct_scaled;
  logic [39:0]      bps_sat;
  logic [23:0]      fr_sat;

  // Window length beyond the store depth acts as the full depth.
  assign w_eff = ({{(CW-7){1'b0}}, win_len_q} > DEPTH_C) ? DEPTH_C
                                                          : {{(CW-7){1'b0}}, win_len_q};

  assign in_acc   = req_i.valid && in_ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign bytes_sum   = {1'b0, bytes_q} + {25'd0, req_i.frame_bytes};
  // Multiplication by 8000 as 8192 - 128 - 64.
  assign bytes_x8000 = ({16'd0, bytes_q} << 13) - ({16'd0, bytes_q} << 7)
                       - ({16'd0, bytes_q} << 6);
  assign frame_prod  = 52'(frames_q) * 52'(USEC_PER_SEC);
  assign di_now      = req_i.cpu_idle_ticks - last_idle_q;
  assign dt_now      = req_i.cpu_total_ticks - last_total_q;
  assign br_n        = (br_samples_q == CNT32_MAX) ? CNT32_MAX : br_samples_q + 32'd1;
  assign rp_n        = (rp_samples_q == CNT32_MAX) ? CNT32_MAX : rp_samples_q + 32'd1;
  assign br_x        = {latest_q, 8'd0};
  // An entry is valid once the sample count has passed its slot since the last clear.
  assign old_val     = (br_samples_q > 32'(slot_q)) ? mem_rdata : 40'd0;
  assign sum_new     = (sum_q - SUM_W'(old_val)) + SUM_W'(latest_q);
  assign busy_ticks  = (di_q > dt_q) ? 32'd0 : dt_q - di_q;
  assign pct_prod    = 42'(busy_ticks) * 42'(PERMILLE);
  assign pct_scaled  = (19'(div_q[9:0]) + 19'(ROUND_HALF)) * 19'(DIV10_RECIP);
  assign bps_sat     = (|div_q[63:40]) ? '1 : div_q[39:0];
  assign fr_sat      = (|div_q[63:24]) ? '1 : div_q[23:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_i.req_type == REQ_BITRATE) begin
            state_d = (interval_q == 16'd0) ? ST_DONE : ST_BR_BPS;
          end else if (req_i.req_type == REQ_REPORT) begin
            state_d = ST_RP_FR_GO;
          end
        end
      end
      ST_BR_BPS:     if (div_done) state_d = ST_BR_MEAN_GO;
      ST_BR_MEAN_GO: state_d = (w_eff == '0) ? ST_BR_CUM : ST_BR_WIN_GO;
      ST_BR_WIN_GO:  state_d = ST_BR_WIN;
      ST_BR_CUM:     if (div_done) state_d = ST_DONE;
      ST_BR_WIN:     if (div_done) state_d = ST_DONE;
      ST_RP_FR_GO:   state_d = ST_RP_FR;
      ST_RP_FR:      if (div_done) state_d = ST_RP_CUM_GO;
      ST_RP_CUM_GO:  state_d = ST_RP_CUM;
      ST_RP_CUM: begin
        if (div_done) state_d = (dt_q == 32'd0) ? ST_DONE : ST_RP_PCT_GO;
      end
      ST_RP_PCT_GO:  state_d = ST_RP_PCT;
      ST_RP_PCT:     if (div_done) state_d = ST_DONE;
      ST_DONE:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: request ready, divider operands and memory write.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mem_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req_i.valid && req_i.req_type == REQ_BITRATE && interval_q != 16'd0) begin
          div_start = 1'b1;
          div_dvd   = bytes_x8000;
          div_dvs   = 48'(interval_q);
        end
      end
      ST_BR_MEAN_GO: begin
        if (w_eff == '0) begin
          div_start = 1'b1;
          div_dvd   = 64'((br_x < mean_br_q) ? mean_br_q - br_x : br_x - mean_br_q);
          div_dvs   = 48'(br_n);
        end else begin
          mem_we = 1'b1;
        end
      end
      ST_BR_WIN_GO: begin
        div_start = 1'b1;
        div_dvd   = 64'({sum_q, 8'd0});
        div_dvs   = 48'(w_eff);
      end
      ST_RP_FR_GO: begin
        div_start = 1'b1;
        div_dvd   = {prod_q[55:0], 8'd0};
        div_dvs   = 48'(us_q);
      end
      ST_RP_CUM_GO: begin
        div_start = 1'b1;
        div_dvd   = 64'((fr_q < mean_fr_q) ? mean_fr_q - fr_q : fr_q - mean_fr_q);
        div_dvs   = 48'(rp_n);
      end
      ST_RP_PCT_GO: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dvs   = 48'(dt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= 7'd0;
      interval_q   <= 16'd1000;
      bytes_q      <= '0;
      frames_q     <= '0;
      br_samples_q <= '0;
      rp_samples_q <= '0;
      latest_q     <= '0;
      mean_br_q    <= '0;
      sum_q        <= '0;
      slot_q       <= '0;
      mean_fr_q    <= '0;
      last_idle_q  <= '0;
      last_total_q <= '0;
      kind_q       <= KIND_BITRATE;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WINDOW) begin
          win_len_q    <= cfg_data_i[6:0];
          sum_q        <= '0;
          br_samples_q <= '0;
          mean_br_q    <= '0;
          slot_q       <= '0;
        end else begin
          interval_q <= cfg_data_i;
        end
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (req_i.req_type == REQ_FRAME) begin
              bytes_q  <= bytes_sum[48] ? BYTES_MAX : bytes_sum[47:0];
              frames_q <= (frames_q == CNT32_MAX) ? CNT32_MAX : frames_q + 32'd1;
            end else if (req_i.req_type == REQ_BITRATE) begin
              kind_q <= KIND_BITRATE;
              if (interval_q != 16'd0) bytes_q <= '0;
            end else if (req_i.req_type == REQ_REPORT) begin
              kind_q       <= KIND_REPORT;
              frames_q     <= '0;
              last_idle_q  <= req_i.cpu_idle_ticks;
              last_total_q <= req_i.cpu_total_ticks;
            end
          end
        end
        ST_BR_BPS: if (div_done) latest_q <= bps_sat;
        ST_BR_MEAN_GO: if (w_eff != '0) sum_q <= sum_new;
        ST_BR_CUM: begin
          if (div_done) begin
            mean_br_q    <= neg_q ? mean_br_q - div_q[47:0] : mean_br_q + div_q[47:0];
            br_samples_q <= br_n;
          end
        end
        ST_BR_WIN: begin
          if (div_done) begin
            mean_br_q    <= div_q[47:0];
            br_samples_q <= br_n;
            // A saturated sample count keeps writing the same slot.
            if (br_samples_q != CNT32_MAX) begin
              slot_q <= ({{(CW-SW){1'b0}}, slot_q} + CW'(1) == w_eff) ? '0
                                                                      : slot_q + 1'b1;
            end
          end
        end
        ST_RP_CUM: begin
          if (div_done) begin
            mean_fr_q    <= neg_q ? mean_fr_q - div_q[23:0] : mean_fr_q + div_q[23:0];
            rp_samples_q <= rp_n;
          end
        end
        default: ;
      endcase
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && req_i.req_type == REQ_REPORT) begin
          prod_q <= 64'(frame_prod);
          us_q   <= (req_i.elapsed_us == 32'd0) ? 32'd1 : req_i.elapsed_us;
          di_q   <= di_now;
          dt_q   <= dt_now;
          pct_q  <= '0;
        end
      end
      ST_BR_MEAN_GO: neg_q <= br_x < mean_br_q;
      ST_RP_FR: if (div_done) fr_q <= fr_sat;
      ST_RP_CUM_GO: neg_q <= fr_q < mean_fr_q;
      ST_RP_CUM: if (div_done) prod_q <= 64'(pct_prod);
      ST_RP_PCT: if (div_done) pct_q <= pct_scaled[17:11];
      ST_DONE: begin
        if (out_free) begin
          out_kind_q <= kind_q;
          out_bps_q  <= latest_q;
          out_mean_q <= mean_br_q;
          out_fr_q   <= (kind_q == KIND_REPORT) ? fr_q : '0;
          out_mfr_q  <= (kind_q == KIND_REPORT) ? mean_fr_q : '0;
          out_pct_q  <= (kind_q == KIND_REPORT) ? pct_q : '0;
        end
      end
      default: ;
    endcase
  end

  trm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  trm_win_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (SW)
  ) u_win_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (latest_q),
    .raddr_i (slot_q),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready               = in_ready;
  assign res_o.valid               = out_valid_q;
  assign res_o.report_kind         = out_kind_q;
  assign res_o.bits_per_second     = out_bps_q;
  assign res_o.mean_bits_q8        = out_mean_q;
  assign res_o.frames_rate_q8      = out_fr_q;
  assign res_o.mean_frames_rate_q8 = out_mfr_q;
  assign res_o.cpu_busy_percent    = out_pct_q;

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_eff != '0) |-> ({{(CW-SW){1'b0}}, slot_q} < w_eff))
    else $error("window slot outside the window length");

  a_tick_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req_i.req_type == REQ_BITRATE || req_i.req_type == REQ_REPORT))
      |=> !req_i.ready)
    else $error("request side ready straight after a tick");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_REPORT) |-> (out_pct_q <= 7'd100))
    else $error("busy percentage above one hundred");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("divider finished straight after a start");

endmodule
